// File: rtl/lfu_pkg.sv
package lfu_pkg;

	// line store geometry
	localparam int LINE_BYTES  = 64;
	localparam int STORE_DEPTH = LINE_BYTES - 1;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(LINE_BYTES);
	localparam int LEN_W       = 6;
	localparam int TOTAL_W     = 32;
	localparam int CODE_W      = 21;

	// byte codes
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_MALFORMED = 2'd1;
	localparam logic [1:0] STAT_OVERSIZED = 2'd2;

	// UTF-8 limits
	localparam logic [7:0]        LEAD_MIN   = 8'hC2;
	localparam logic [7:0]        LEAD_MAX   = 8'hF4;
	localparam logic [7:0]        LEAD_3B    = 8'hE0;
	localparam logic [7:0]        LEAD_4B    = 8'hF0;
	localparam logic [CODE_W-1:0] CP_MAX     = 21'h10FFFF;
	localparam logic [CODE_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [CODE_W-1:0] SURR_HI    = 21'h00DFFF;
	localparam logic [CODE_W-1:0] MIN_2B     = 21'h000080;
	localparam logic [CODE_W-1:0] MIN_3B     = 21'h000800;
	localparam logic [CODE_W-1:0] MIN_4B     = 21'h010000;

	typedef logic [CNT_W-1:0] cnt_t;

endpackage

// File: rtl/line_framer_utf8_check_unit.sv
// Line framer with strict UTF-8 check.
// Flow: a non-newline request is taken and gives no result; a newline that gives a
//   status-only result shows it on rsp_valid in the next cycle; a valid line is read
//   through the store read register into the result register, one byte per cycle
//   while rsp_stall is low. Requests: one byte per cycle while the result register is
//   free; a newline that ends a valid line holds off requests until its line is read out.
// Reset (arst_n low): fill count, overflow mark, UTF-8 state and both totals clear;
//   the line store is not cleared, only entries below the fill count are ever read.
module line_framer_utf8_check_unit
	import lfu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [7:0]         byte_in,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [7:0]         line_byte,
	output logic               byte_valid,
	output logic               last,
	output logic [1:0]         status,
	output logic [LEN_W-1:0]   line_len,
	output logic [TOTAL_W-1:0] oversized_total,
	output logic [TOTAL_W-1:0] malformed_total
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	// line store, one write port (collect) and one registered read port (readout)
	logic [7:0] mem [STORE_DEPTH];
	logic [7:0] rd_data_s1;

	logic state_q;

	// collect-side state
	cnt_t fill_q;
	logic ovf_q;
	logic last_cr_q;

	// incremental UTF-8 checker state
	logic [1:0]        need_q;   // continuation bytes still expected
	logic [1:0]        more_q;   // continuation bytes of current sequence
	logic [CODE_W-1:0] code_q;
	logic              bad_q;

	logic [TOTAL_W-1:0] ovs_cnt_q;
	logic [TOTAL_W-1:0] mal_cnt_q;

	// readout
	cnt_t rd_addr_q;
	cnt_t rd_len_q;
	logic s1_valid;
	logic last_s1;

	// result register
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_bvalid_q;
	logic             out_last_q;
	logic [1:0]       out_status_q;
	logic [LEN_W-1:0] out_len_q;

	logic       out_free;
	logic       accept;
	logic       is_lf;
	logic       full;
	logic       wr_en;
	cnt_t       n_strip;
	logic [6:0] n_wide;
	logic [6:0] rd_len_wide;
	logic       line_bad;

	logic       rd_more;
	logic       issue;
	logic       pop;
	cnt_t       rd_addr_nx;

	// UTF-8 next-state
	logic [1:0]        lead_more;
	logic [CODE_W-1:0] lead_code;
	logic [CODE_W-1:0] cont_code;
	logic              lead_bad;
	logic              cont_bad;
	logic              seq_bad;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;
	assign is_lf     = (byte_in == CH_LF);
	assign full      = (fill_q == cnt_t'(STORE_DEPTH));
	assign wr_en     = accept && !is_lf && !ovf_q && !full;

	// length after one trailing carriage return is stripped
	assign n_strip     = (fill_q != '0 && last_cr_q) ? fill_q - cnt_t'(1) : fill_q;
	assign n_wide      = 7'(n_strip);
	assign rd_len_wide = 7'(rd_len_q);
	// a sequence still open at the line end is a truncated one
	assign line_bad = bad_q || (need_q != 2'd0);

	always_comb begin
		lead_more = 2'd1;
		if (byte_in >= LEAD_4B)
			lead_more = 2'd3;
		else if (byte_in >= LEAD_3B)
			lead_more = 2'd2;
		case (lead_more)
			2'd1:    lead_code = CODE_W'(byte_in[4:0]);
			2'd2:    lead_code = CODE_W'(byte_in[3:0]);
			default: lead_code = CODE_W'(byte_in[2:0]);
		endcase
		lead_bad  = byte_in[7] && (byte_in < LEAD_MIN || byte_in > LEAD_MAX);
		cont_code = {code_q[CODE_W-7:0], byte_in[5:0]};
		cont_bad  = (byte_in[7:6] != 2'b10);
		// range, surrogate and overlong checks once the sequence completes
		seq_bad = (cont_code > CP_MAX) ||
			(cont_code >= SURR_LO && cont_code <= SURR_HI) ||
			(more_q == 2'd1 && cont_code < MIN_2B) ||
			(more_q == 2'd2 && cont_code < MIN_3B) ||
			(more_q == 2'd3 && cont_code < MIN_4B);
	end

	// readout: while bytes remain, issue a store read whenever the read stage is empty or drains
	assign rd_more    = (rd_addr_q != rd_len_q);
	assign pop        = (state_q == ST_READ) && s1_valid && out_free;
	assign issue      = (state_q == ST_READ) && rd_more && (!s1_valid || out_free);
	assign rd_addr_nx = rd_addr_q + cnt_t'(1);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[fill_q[ADDR_W-1:0]] <= byte_in;
		if (issue)
			rd_data_s1 <= mem[rd_addr_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			last_cr_q   <= 1'b0;
			need_q      <= 2'd0;
			more_q      <= 2'd0;
			code_q      <= '0;
			bad_q       <= 1'b0;
			ovs_cnt_q   <= '0;
			mal_cnt_q   <= '0;
			rd_addr_q   <= '0;
			rd_len_q    <= '0;
			s1_valid    <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !rsp_stall)
				out_valid_q <= 1'b0;

			if (accept && !is_lf) begin
				if (!ovf_q && full)
					ovf_q <= 1'b1;
				if (wr_en) begin
					fill_q    <= fill_q + cnt_t'(1);
					last_cr_q <= (byte_in == CH_CR);
					if (need_q == 2'd0) begin
						if (byte_in[7]) begin
							if (lead_bad) begin
								bad_q <= 1'b1;
							end else begin
								need_q <= lead_more;
								more_q <= lead_more;
								code_q <= lead_code;
							end
						end
					end else begin
						need_q <= need_q - 2'd1;
						code_q <= cont_code;
						if (cont_bad || (need_q == 2'd1 && seq_bad))
							bad_q <= 1'b1;
					end
				end
			end

			if (accept && is_lf) begin
				fill_q    <= '0;
				ovf_q     <= 1'b0;
				last_cr_q <= 1'b0;
				need_q    <= 2'd0;
				more_q    <= 2'd0;
				bad_q     <= 1'b0;
				if (ovf_q) begin
					ovs_cnt_q    <= ovs_cnt_q + TOTAL_W'(1);
					out_valid_q  <= 1'b1;
					out_bvalid_q <= 1'b0;
					out_last_q   <= 1'b1;
					out_status_q <= STAT_OVERSIZED;
					out_len_q    <= '0;
					out_byte_q   <= '0;
				end else if (line_bad) begin
					mal_cnt_q    <= mal_cnt_q + TOTAL_W'(1);
					out_valid_q  <= 1'b1;
					out_bvalid_q <= 1'b0;
					out_last_q   <= 1'b1;
					out_status_q <= STAT_MALFORMED;
					out_len_q    <= n_wide[LEN_W-1:0];
					out_byte_q   <= '0;
				end else if (n_strip == '0) begin
					out_valid_q  <= 1'b1;
					out_bvalid_q <= 1'b0;
					out_last_q   <= 1'b1;
					out_status_q <= STAT_OK;
					out_len_q    <= '0;
					out_byte_q   <= '0;
				end else begin
					state_q   <= ST_READ;
					rd_addr_q <= '0;
					rd_len_q  <= n_strip;
				end
			end

			if (issue) begin
				rd_addr_q <= rd_addr_nx;
				last_s1   <= (rd_addr_nx == rd_len_q);
			end
			s1_valid <= issue || (s1_valid && !pop);

			if (pop) begin
				out_valid_q  <= 1'b1;
				out_bvalid_q <= 1'b1;
				out_last_q   <= last_s1;
				out_status_q <= STAT_OK;
				out_len_q    <= rd_len_wide[LEN_W-1:0];
				out_byte_q   <= rd_data_s1;
				if (last_s1)
					state_q <= ST_IDLE;
			end
		end
	end

	assign rsp_valid       = out_valid_q;
	assign line_byte       = out_byte_q;
	assign byte_valid      = out_bvalid_q;
	assign last            = out_last_q;
	assign status          = out_status_q;
	assign line_len        = out_len_q;
	assign oversized_total = ovs_cnt_q;
	assign malformed_total = mal_cnt_q;

endmodule
